### src/gda_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date advance package
// Widths, codes, control word layout, microcode program and calendar tables
// shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int DELTA_W = 23;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 25;
  localparam int PC_W    = 5;
  localparam int OP_W    = 5;
  localparam int COND_W  = 5;

  typedef logic signed [CNT_W-1:0] cnt_t;

  localparam cnt_t DAYS_400 = cnt_t'(146097);
  localparam cnt_t DAYS_100 = cnt_t'(36524);
  localparam cnt_t DAYS_4   = cnt_t'(1460);
  localparam cnt_t DAYS_1   = cnt_t'(365);
  localparam cnt_t CNT_ONE  = cnt_t'(1);

  localparam logic OP_SET = 1'b0;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_SET = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [OP_W-1:0] DP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] DP_CAPTURE    = 5'd1;
  localparam logic [OP_W-1:0] DP_REJ_SET    = 5'd2;
  localparam logic [OP_W-1:0] DP_Y400       = 5'd3;
  localparam logic [OP_W-1:0] DP_Y100       = 5'd4;
  localparam logic [OP_W-1:0] DP_Y4         = 5'd5;
  localparam logic [OP_W-1:0] DP_Y1         = 5'd6;
  localparam logic [OP_W-1:0] DP_MADD       = 5'd7;
  localparam logic [OP_W-1:0] DP_DELTA      = 5'd8;
  localparam logic [OP_W-1:0] DP_REJ_ADV    = 5'd9;
  localparam logic [OP_W-1:0] DP_INV_INIT   = 5'd10;
  localparam logic [OP_W-1:0] DP_I400       = 5'd11;
  localparam logic [OP_W-1:0] DP_I100       = 5'd12;
  localparam logic [OP_W-1:0] DP_I4         = 5'd13;
  localparam logic [OP_W-1:0] DP_I1         = 5'd14;
  localparam logic [OP_W-1:0] DP_IM         = 5'd15;
  localparam logic [OP_W-1:0] DP_COMMIT_ADV = 5'd16;
  localparam logic [OP_W-1:0] DP_COMMIT_SET = 5'd17;
  localparam logic [OP_W-1:0] DP_SHOW       = 5'd18;

  localparam logic [COND_W-1:0] C_ALWAYS    = 5'd0;
  localparam logic [COND_W-1:0] C_XFER      = 5'd1;
  localparam logic [COND_W-1:0] C_OUT_FREE  = 5'd2;
  localparam logic [COND_W-1:0] C_BAD_YEAR  = 5'd3;
  localparam logic [COND_W-1:0] C_RY400     = 5'd4;
  localparam logic [COND_W-1:0] C_RY100     = 5'd5;
  localparam logic [COND_W-1:0] C_RY4       = 5'd6;
  localparam logic [COND_W-1:0] C_RY1       = 5'd7;
  localparam logic [COND_W-1:0] C_OP_SET    = 5'd8;
  localparam logic [COND_W-1:0] C_MON_LT    = 5'd9;
  localparam logic [COND_W-1:0] C_RANGE_BAD = 5'd10;
  localparam logic [COND_W-1:0] C_A400      = 5'd11;
  localparam logic [COND_W-1:0] C_A100      = 5'd12;
  localparam logic [COND_W-1:0] C_A4        = 5'd13;
  localparam logic [COND_W-1:0] C_A1        = 5'd14;
  localparam logic [COND_W-1:0] C_AM        = 5'd15;
  localparam logic [COND_W-1:0] C_SET_BAD   = 5'd16;

  localparam logic [PC_W-1:0] PC_IDLE   = 5'd0;
  localparam logic [PC_W-1:0] PC_CHK    = 5'd1;
  localparam logic [PC_W-1:0] PC_Y400   = 5'd2;
  localparam logic [PC_W-1:0] PC_Y100   = 5'd3;
  localparam logic [PC_W-1:0] PC_Y4     = 5'd4;
  localparam logic [PC_W-1:0] PC_Y1     = 5'd5;
  localparam logic [PC_W-1:0] PC_BR     = 5'd6;
  localparam logic [PC_W-1:0] PC_MADD   = 5'd7;
  localparam logic [PC_W-1:0] PC_DELTA  = 5'd8;
  localparam logic [PC_W-1:0] PC_RANGE  = 5'd9;
  localparam logic [PC_W-1:0] PC_INV    = 5'd10;
  localparam logic [PC_W-1:0] PC_I400   = 5'd11;
  localparam logic [PC_W-1:0] PC_I100   = 5'd12;
  localparam logic [PC_W-1:0] PC_I4     = 5'd13;
  localparam logic [PC_W-1:0] PC_I1     = 5'd14;
  localparam logic [PC_W-1:0] PC_IM     = 5'd15;
  localparam logic [PC_W-1:0] PC_COMMIT = 5'd16;
  localparam logic [PC_W-1:0] PC_SETCHK = 5'd17;
  localparam logic [PC_W-1:0] PC_SETOK  = 5'd18;
  localparam logic [PC_W-1:0] PC_OUT    = 5'd19;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   tgt;
    logic              hold;
  } ctl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            exec;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_year;
    logic ry400;
    logic ry100;
    logic ry4;
    logic ry1;
    logic op_set;
    logic mon_lt;
    logic range_bad;
    logic a400;
    logic a100;
    logic a4;
    logic a1;
    logic am;
    logic set_bad;
  } dp_flags_t;

  // When the condition holds, the operation runs and control jumps to the
  // target; otherwise control holds or falls through to the next step.
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    unique case (pc)
      PC_IDLE:   w = '{op: DP_CAPTURE,    cond: C_XFER,      tgt: PC_CHK,    hold: 1'b1};
      PC_CHK:    w = '{op: DP_REJ_SET,    cond: C_BAD_YEAR,  tgt: PC_OUT,    hold: 1'b0};
      PC_Y400:   w = '{op: DP_Y400,       cond: C_RY400,     tgt: PC_Y400,   hold: 1'b0};
      PC_Y100:   w = '{op: DP_Y100,       cond: C_RY100,     tgt: PC_Y100,   hold: 1'b0};
      PC_Y4:     w = '{op: DP_Y4,         cond: C_RY4,       tgt: PC_Y4,     hold: 1'b0};
      PC_Y1:     w = '{op: DP_Y1,         cond: C_RY1,       tgt: PC_Y1,     hold: 1'b0};
      PC_BR:     w = '{op: DP_NOP,        cond: C_OP_SET,    tgt: PC_SETCHK, hold: 1'b0};
      PC_MADD:   w = '{op: DP_MADD,       cond: C_MON_LT,    tgt: PC_MADD,   hold: 1'b0};
      PC_DELTA:  w = '{op: DP_DELTA,      cond: C_ALWAYS,    tgt: PC_RANGE,  hold: 1'b0};
      PC_RANGE:  w = '{op: DP_REJ_ADV,    cond: C_RANGE_BAD, tgt: PC_OUT,    hold: 1'b0};
      PC_INV:    w = '{op: DP_INV_INIT,   cond: C_ALWAYS,    tgt: PC_I400,   hold: 1'b0};
      PC_I400:   w = '{op: DP_I400,       cond: C_A400,      tgt: PC_I400,   hold: 1'b0};
      PC_I100:   w = '{op: DP_I100,       cond: C_A100,      tgt: PC_I100,   hold: 1'b0};
      PC_I4:     w = '{op: DP_I4,         cond: C_A4,        tgt: PC_I4,     hold: 1'b0};
      PC_I1:     w = '{op: DP_I1,         cond: C_A1,        tgt: PC_I1,     hold: 1'b0};
      PC_IM:     w = '{op: DP_IM,         cond: C_AM,        tgt: PC_IM,     hold: 1'b0};
      PC_COMMIT: w = '{op: DP_COMMIT_ADV, cond: C_ALWAYS,    tgt: PC_OUT,    hold: 1'b0};
      PC_SETCHK: w = '{op: DP_REJ_SET,    cond: C_SET_BAD,   tgt: PC_OUT,    hold: 1'b0};
      PC_SETOK:  w = '{op: DP_COMMIT_SET, cond: C_ALWAYS,    tgt: PC_OUT,    hold: 1'b0};
      PC_OUT:    w = '{op: DP_SHOW,       cond: C_OUT_FREE,  tgt: PC_IDLE,   hold: 1'b1};
      default:   w = '{op: DP_NOP,        cond: C_ALWAYS,    tgt: PC_IDLE,   hold: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

### src/gda_dp.sv
// ----------------------------------------------------------------------------
// Gregorian date advance datapath
// Holds the stored date, the day count accumulator, the year and month walk
// registers and the result registers, and reports branch conditions.
// ----------------------------------------------------------------------------
module gda_dp #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gda_pkg::dp_cmd_t                    cmd,
  input  logic                                in_operation,
  input  logic [gda_pkg::YEAR_W-1:0]          in_new_year,
  input  logic [gda_pkg::MON_W-1:0]           in_new_month,
  input  logic [gda_pkg::DAY_W-1:0]           in_new_day,
  input  logic signed [gda_pkg::DELTA_W-1:0]  in_day_delta,
  output gda_pkg::dp_flags_t                  flags,
  output logic [gda_pkg::YEAR_W-1:0]          out_cur_year,
  output logic [gda_pkg::MON_W-1:0]           out_cur_month,
  output logic [gda_pkg::DAY_W-1:0]           out_cur_day,
  output logic [gda_pkg::ST_W-1:0]            out_status
);

  localparam int LIMIT_I = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
                         - (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400;
  localparam gda_pkg::cnt_t LIMIT = gda_pkg::cnt_t'(LIMIT_I);

  localparam logic [gda_pkg::YEAR_W-1:0] Y400 = gda_pkg::YEAR_W'(400);
  localparam logic [gda_pkg::YEAR_W-1:0] Y100 = gda_pkg::YEAR_W'(100);
  localparam logic [gda_pkg::YEAR_W-1:0] Y4   = gda_pkg::YEAR_W'(4);
  localparam logic [gda_pkg::YEAR_W-1:0] Y1   = gda_pkg::YEAR_W'(1);
  localparam logic [gda_pkg::YEAR_W-1:0] YMAX = gda_pkg::YEAR_W'(MAX_YEAR);

  logic                               op_r, op_nxt;
  logic [gda_pkg::YEAR_W-1:0]         ny_r, ny_nxt;
  logic [gda_pkg::MON_W-1:0]          nm_r, nm_nxt;
  logic [gda_pkg::DAY_W-1:0]          nd_r, nd_nxt;
  logic signed [gda_pkg::DELTA_W-1:0] dl_r, dl_nxt;
  logic [gda_pkg::YEAR_W-1:0]         ry_r, ry_nxt;
  logic [gda_pkg::YEAR_W-1:0]         b_r, b_nxt;
  logic                               m4_r, m4_nxt;
  logic                               m100_r, m100_nxt;
  logic                               m400_r, m400_nxt;
  gda_pkg::cnt_t                      acc_r, acc_nxt;
  logic [gda_pkg::MON_W-1:0]          mon_r, mon_nxt;
  logic [gda_pkg::YEAR_W-1:0]         year_r, year_nxt;
  logic [gda_pkg::MON_W-1:0]          month_r, month_nxt;
  logic [gda_pkg::DAY_W-1:0]          day_r, day_nxt;
  logic [gda_pkg::ST_W-1:0]           st_r, st_nxt;
  logic [gda_pkg::YEAR_W-1:0]         oy_r, oy_nxt;
  logic [gda_pkg::MON_W-1:0]          om_r, om_nxt;
  logic [gda_pkg::DAY_W-1:0]          od_r, od_nxt;
  logic [gda_pkg::ST_W-1:0]           ost_r, ost_nxt;

  logic                       leap;
  gda_pkg::cnt_t              len100, len4, len1, mlen_c, day_ext, dl_ext;
  logic [gda_pkg::DAY_W-1:0]  nm_len;

  assign leap    = m4_r & (~m100_r | m400_r);
  assign len100  = m400_r ? gda_pkg::DAYS_100 + gda_pkg::CNT_ONE : gda_pkg::DAYS_100;
  assign len4    = leap ? gda_pkg::DAYS_4 + gda_pkg::CNT_ONE : gda_pkg::DAYS_4;
  assign len1    = leap ? gda_pkg::DAYS_1 + gda_pkg::CNT_ONE : gda_pkg::DAYS_1;
  assign mlen_c  = gda_pkg::cnt_t'({{(gda_pkg::CNT_W - gda_pkg::DAY_W){1'b0}},
                                    gda_pkg::month_len(mon_r, leap)});
  assign day_ext = gda_pkg::cnt_t'({{(gda_pkg::CNT_W - gda_pkg::DAY_W){1'b0}}, day_r});
  assign dl_ext  = gda_pkg::cnt_t'(dl_r);
  assign nm_len  = gda_pkg::month_len(nm_r, leap);

  always_comb begin
    flags.op_set    = (op_r == gda_pkg::OP_SET);
    flags.bad_year  = flags.op_set && (ny_r > YMAX);
    flags.ry400     = ry_r >= Y400;
    flags.ry100     = ry_r >= Y100;
    flags.ry4       = ry_r >= Y4;
    flags.ry1       = ry_r >= Y1;
    flags.mon_lt    = mon_r < month_r;
    flags.range_bad = (acc_r < gda_pkg::CNT_ONE) || (acc_r > LIMIT);
    flags.a400      = acc_r >= gda_pkg::DAYS_400;
    flags.a100      = acc_r >= len100;
    flags.a4        = acc_r >= len4;
    flags.a1        = acc_r >= len1;
    flags.am        = acc_r >= mlen_c;
    flags.set_bad   = (nm_r == 4'd0) || (nm_r > 4'd12) || (nd_r == 5'd0) || (nd_r > nm_len);
  end

  always_comb begin
    op_nxt    = op_r;
    ny_nxt    = ny_r;
    nm_nxt    = nm_r;
    nd_nxt    = nd_r;
    dl_nxt    = dl_r;
    ry_nxt    = ry_r;
    b_nxt     = b_r;
    m4_nxt    = m4_r;
    m100_nxt  = m100_r;
    m400_nxt  = m400_r;
    acc_nxt   = acc_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    st_nxt    = st_r;
    oy_nxt    = oy_r;
    om_nxt    = om_r;
    od_nxt    = od_r;
    ost_nxt   = ost_r;
    if (cmd.exec) begin
      unique case (cmd.op)
        gda_pkg::DP_CAPTURE: begin
          op_nxt   = in_operation;
          ny_nxt   = in_new_year;
          nm_nxt   = in_new_month;
          nd_nxt   = in_new_day;
          dl_nxt   = in_day_delta;
          ry_nxt   = (in_operation == gda_pkg::OP_SET) ? in_new_year : year_r;
          b_nxt    = '0;
          m4_nxt   = 1'b1;
          m100_nxt = 1'b1;
          m400_nxt = 1'b1;
          acc_nxt  = '0;
          mon_nxt  = 4'd1;
          st_nxt   = gda_pkg::ST_OK;
        end
        gda_pkg::DP_REJ_SET: st_nxt = gda_pkg::ST_BAD_SET;
        gda_pkg::DP_REJ_ADV: st_nxt = gda_pkg::ST_RANGE;
        gda_pkg::DP_Y400: begin
          ry_nxt  = ry_r - Y400;
          b_nxt   = b_r + Y400;
          acc_nxt = acc_r + gda_pkg::DAYS_400;
        end
        gda_pkg::DP_Y100: begin
          ry_nxt   = ry_r - Y100;
          b_nxt    = b_r + Y100;
          acc_nxt  = acc_r + len100;
          m400_nxt = 1'b0;
        end
        gda_pkg::DP_Y4: begin
          ry_nxt   = ry_r - Y4;
          b_nxt    = b_r + Y4;
          acc_nxt  = acc_r + len4;
          m100_nxt = 1'b0;
          m400_nxt = 1'b0;
        end
        gda_pkg::DP_Y1: begin
          ry_nxt   = ry_r - Y1;
          b_nxt    = b_r + Y1;
          acc_nxt  = acc_r + len1;
          m4_nxt   = 1'b0;
          m100_nxt = 1'b0;
          m400_nxt = 1'b0;
        end
        gda_pkg::DP_MADD: begin
          acc_nxt = acc_r + mlen_c;
          mon_nxt = mon_r + 4'd1;
        end
        gda_pkg::DP_DELTA: acc_nxt = acc_r + day_ext + dl_ext;
        gda_pkg::DP_INV_INIT: begin
          acc_nxt  = acc_r - gda_pkg::CNT_ONE;
          b_nxt    = '0;
          m4_nxt   = 1'b1;
          m100_nxt = 1'b1;
          m400_nxt = 1'b1;
          mon_nxt  = 4'd1;
        end
        gda_pkg::DP_I400: begin
          acc_nxt = acc_r - gda_pkg::DAYS_400;
          b_nxt   = b_r + Y400;
        end
        gda_pkg::DP_I100: begin
          acc_nxt  = acc_r - len100;
          b_nxt    = b_r + Y100;
          m400_nxt = 1'b0;
        end
        gda_pkg::DP_I4: begin
          acc_nxt  = acc_r - len4;
          b_nxt    = b_r + Y4;
          m100_nxt = 1'b0;
          m400_nxt = 1'b0;
        end
        gda_pkg::DP_I1: begin
          acc_nxt  = acc_r - len1;
          b_nxt    = b_r + Y1;
          m4_nxt   = 1'b0;
          m100_nxt = 1'b0;
          m400_nxt = 1'b0;
        end
        gda_pkg::DP_IM: begin
          acc_nxt = acc_r - mlen_c;
          mon_nxt = mon_r + 4'd1;
        end
        gda_pkg::DP_COMMIT_ADV: begin
          year_nxt  = b_r;
          month_nxt = mon_r;
          day_nxt   = acc_r[gda_pkg::DAY_W-1:0] + 5'd1;
        end
        gda_pkg::DP_COMMIT_SET: begin
          year_nxt  = ny_r;
          month_nxt = nm_r;
          day_nxt   = nd_r;
        end
        gda_pkg::DP_SHOW: begin
          oy_nxt  = year_r;
          om_nxt  = month_r;
          od_nxt  = day_r;
          ost_nxt = st_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= '0;
      month_r <= 4'd1;
      day_r   <= 5'd1;
    end else begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    ny_r   <= ny_nxt;
    nm_r   <= nm_nxt;
    nd_r   <= nd_nxt;
    dl_r   <= dl_nxt;
    ry_r   <= ry_nxt;
    b_r    <= b_nxt;
    m4_r   <= m4_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
    acc_r  <= acc_nxt;
    mon_r  <= mon_nxt;
    st_r   <= st_nxt;
    oy_r   <= oy_nxt;
    om_r   <= om_nxt;
    od_r   <= od_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_cur_year  = oy_r;
  assign out_cur_month = om_r;
  assign out_cur_day   = od_r;
  assign out_status    = ost_r;

endmodule

### src/gregorian_date_advance_top.sv
// ----------------------------------------------------------------------------
// Gregorian date advance
// Stored date with checked set and signed day advance, run by a microcoded
// sequencer over a walk of 400, 100, 4 and 1 year blocks and of months.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_operation, in_new_year,
//                     in_new_month, in_new_day, in_day_delta
// out      output     out_valid, out_ready, out_cur_year, out_cur_month,
//                     out_cur_day, out_status
//
// One item is worked at a time; in_ready is high only while the program
// waits at its idle step. An advance runs its block walks through one shared
// accumulator. The result sits in an output register, so a stalled out
// channel holds only the final step. Reset loads the date 0-01-01 and
// clears out_valid.
// ----------------------------------------------------------------------------
module gregorian_date_advance_top #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic [gda_pkg::YEAR_W-1:0]          in_new_year,
  input  logic [gda_pkg::MON_W-1:0]           in_new_month,
  input  logic [gda_pkg::DAY_W-1:0]           in_new_day,
  input  logic signed [gda_pkg::DELTA_W-1:0]  in_day_delta,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gda_pkg::YEAR_W-1:0]          out_cur_year,
  output logic [gda_pkg::MON_W-1:0]           out_cur_month,
  output logic [gda_pkg::DAY_W-1:0]           out_cur_day,
  output logic [gda_pkg::ST_W-1:0]            out_status
);

  logic [gda_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  gda_pkg::ctl_t            ctl;
  gda_pkg::dp_cmd_t         cmd;
  gda_pkg::dp_flags_t       flags;
  logic                     in_xfer;
  logic                     out_free;
  logic                     cond_ok;

  assign ctl      = gda_pkg::ucode(pc_r);
  assign in_ready = (pc_r == gda_pkg::PC_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    unique case (ctl.cond)
      gda_pkg::C_ALWAYS:    cond_ok = 1'b1;
      gda_pkg::C_XFER:      cond_ok = in_xfer;
      gda_pkg::C_OUT_FREE:  cond_ok = out_free;
      gda_pkg::C_BAD_YEAR:  cond_ok = flags.bad_year;
      gda_pkg::C_RY400:     cond_ok = flags.ry400;
      gda_pkg::C_RY100:     cond_ok = flags.ry100;
      gda_pkg::C_RY4:       cond_ok = flags.ry4;
      gda_pkg::C_RY1:       cond_ok = flags.ry1;
      gda_pkg::C_OP_SET:    cond_ok = flags.op_set;
      gda_pkg::C_MON_LT:    cond_ok = flags.mon_lt;
      gda_pkg::C_RANGE_BAD: cond_ok = flags.range_bad;
      gda_pkg::C_A400:      cond_ok = flags.a400;
      gda_pkg::C_A100:      cond_ok = flags.a100;
      gda_pkg::C_A4:        cond_ok = flags.a4;
      gda_pkg::C_A1:        cond_ok = flags.a1;
      gda_pkg::C_AM:        cond_ok = flags.am;
      gda_pkg::C_SET_BAD:   cond_ok = flags.set_bad;
      default:              cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd.op   = ctl.op;
    cmd.exec = cond_ok;
    if (cond_ok) begin
      pc_nxt = ctl.tgt;
    end else if (ctl.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + gda_pkg::PC_W'(1);
    end
    if (cond_ok && (ctl.op == gda_pkg::DP_SHOW)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= gda_pkg::PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  gda_dp #(
    .MAX_YEAR(MAX_YEAR)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_operation (in_operation),
    .in_new_year  (in_new_year),
    .in_new_month (in_new_month),
    .in_new_day   (in_new_day),
    .in_day_delta (in_day_delta),
    .flags        (flags),
    .out_cur_year (out_cur_year),
    .out_cur_month(out_cur_month),
    .out_cur_day  (out_cur_day),
    .out_status   (out_status)
  );

  assign out_valid = out_valid_r;

  // A new result appears only from the final step of the program.
  a_show_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r == gda_pkg::PC_OUT))
    else $error("result raised outside the final step");

  // An accepted item always starts at the year check.
  a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (pc_r == gda_pkg::PC_CHK))
    else $error("accepted item did not start the program");

  // A stalled result keeps the program parked at the final step.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == gda_pkg::PC_OUT && out_valid_r && !out_ready) |=> (pc_r == gda_pkg::PC_OUT))
    else $error("program left the final step under a stalled result");

  // Every shown result has a month of 1 to 12, a nonzero day and a defined status.
  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cur_month >= 4'd1 && out_cur_month <= 4'd12 &&
                     out_cur_day >= 5'd1 && out_status != 2'd3))
    else $error("malformed result");

endmodule
